/* rtl/u8u16_pkg.sv */
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; imported by every rtl module and the checker
package u8u16_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_UNIT  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] code_unit;
      status_type  status;
      logic        last_of_run;
   } result_type;

   // all results produced by one input byte
   typedef struct packed {
      logic [1:0]            count;
      result_type [2:0]      slot;
   } batch_type;

   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [20:0] CP_MIN_TWO   = 21'h000080;
   localparam logic [20:0] CP_MIN_THREE = 21'h000800;
   localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

endpackage

/* rtl/u8u16_decoder.sv */
// utf-8 sequence decoder: sequence state registers and one-pass decode
// of the held byte into up to three results; uses u8u16_pkg
module u8u16_decoder
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  in_byte,
   input  logic        string_end,
   input  logic        step,
   output batch_type   batch
);

   logic [20:0] partial_point_ff, partial_point_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]  seq_length_ff, seq_length_in;
   logic        discarding_ff, discarding_in;

   logic        bad;
   logic        quiet;
   logic        go_idle;
   logic [1:0]  n_units;
   logic [15:0] unit0;
   logic [15:0] unit1;
   logic [1:0]  lead_len;
   logic [2:0]  lead_bits;
   logic [20:0] cp;
   logic [20:0] cp_off;
   logic [1:0]  left_dec;

   assign cp       = {partial_point_ff[14:0], in_byte[5:0]};
   assign cp_off   = cp - CP_SUPP_BASE;
   assign left_dec = bytes_left_ff - 2'd1;

   always_comb begin
      bad              = 1'b0;
      quiet            = 1'b0;
      go_idle          = 1'b0;
      n_units          = 2'd0;
      unit0            = 16'd0;
      unit1            = 16'd0;
      lead_len         = 2'd0;
      lead_bits        = 3'd0;
      partial_point_in = partial_point_ff;
      bytes_left_in    = bytes_left_ff;
      seq_length_in    = seq_length_ff;
      discarding_in    = discarding_ff;

      if (discarding_ff) begin
         quiet = 1'b1;
         if (string_end) begin
            discarding_in = 1'b0;
         end
      end else if (bytes_left_ff == 2'd0) begin
         if (in_byte[7] == 1'b0) begin
            n_units = 2'd1;
            unit0   = {8'd0, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            lead_len  = 2'd1;
            lead_bits = 3'b000;
         end else if (in_byte[7:4] == 4'b1110) begin
            lead_len  = 2'd2;
            lead_bits = 3'b000;
         end else if (in_byte[7:3] == 5'b11110) begin
            lead_len  = 2'd3;
            lead_bits = in_byte[2:0];
         end else begin
            bad = 1'b1;
         end
         if (lead_len != 2'd0) begin
            if (string_end) begin
               bad = 1'b1;
            end else begin
               // payload bits of the lead byte, width set by its length
               case (lead_len)
                  2'd1:    partial_point_in = {16'd0, in_byte[4:0]};
                  2'd2:    partial_point_in = {17'd0, in_byte[3:0]};
                  default: partial_point_in = {18'd0, lead_bits};
               endcase
               bytes_left_in = lead_len;
               seq_length_in = lead_len;
            end
         end
      end else if (in_byte[7:6] != 2'b10) begin
         bad = 1'b1;
      end else begin
         partial_point_in = cp;
         bytes_left_in    = left_dec;
         if (left_dec != 2'd0) begin
            if (string_end) begin
               bad = 1'b1;
            end
         end else begin
            case (seq_length_ff)
               2'd1:    bad = (cp < CP_MIN_TWO);
               2'd2:    bad = (cp < CP_MIN_THREE) || ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
               default: bad = (cp < CP_SUPP_BASE) || (cp > CP_MAX);
            endcase
            if (!bad) begin
               go_idle = 1'b1;
               if (cp < CP_SUPP_BASE) begin
                  n_units = 2'd1;
                  unit0   = cp[15:0];
               end else begin
                  n_units = 2'd2;
                  unit0   = HI_SURR_BASE | {6'd0, cp_off[19:10]};
                  unit1   = LO_SURR_BASE | {6'd0, cp_off[9:0]};
               end
            end
         end
      end

      if (!quiet) begin
         if (bad) begin
            go_idle       = 1'b1;
            discarding_in = !string_end;
         end else if (string_end) begin
            go_idle = 1'b1;
         end
      end

      if (go_idle) begin
         partial_point_in = 21'd0;
         bytes_left_in    = 2'd0;
         seq_length_in    = 2'd0;
      end
   end

   // pack units, done and error into result slots
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         batch.slot[k] = '{code_unit: 16'd0, status: ST_UNIT, last_of_run: 1'b0};
      end
      batch.count = 2'd0;
      if (quiet) begin
         batch.count = 2'd0;
      end else if (bad) begin
         batch.slot[0].status = ST_ERROR;
         batch.count          = 2'd1;
      end else begin
         batch.slot[0].code_unit = unit0;
         batch.slot[1].code_unit = unit1;
         if (string_end) begin
            batch.slot[n_units].status = ST_DONE;
         end
         batch.count = n_units + {1'b0, string_end};
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
         batch.slot[k].last_of_run = (batch.count == 2'(k + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_point_ff <= 21'd0;
         bytes_left_ff    <= 2'd0;
         seq_length_ff    <= 2'd0;
         discarding_ff    <= 1'b0;
      end else if (step) begin
         partial_point_ff <= partial_point_in;
         bytes_left_ff    <= bytes_left_in;
         seq_length_ff    <= seq_length_in;
         discarding_ff    <= discarding_in;
      end
   end

endmodule

/* rtl/u8u16_result_queue.sv */
// result register: holds the results of one byte and hands them out
// one transaction per cycle while rsp_stall is low; uses u8u16_pkg
module u8u16_result_queue
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load_valid,
   input  batch_type   batch,
   output logic        load,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run
);

   result_type [2:0] slot_ff;
   logic [1:0]       count_ff, count_in;
   logic [1:0]       index_ff, index_in;
   result_type       head;
   logic             take;
   logic             last_take;

   assign rsp_valid = (count_ff != 2'd0);
   assign take      = rsp_valid && !rsp_stall;
   assign last_take = take && (index_ff == (count_ff - 2'd1));
   assign load      = load_valid && (!rsp_valid || last_take);

   always_comb begin
      case (index_ff)
         2'd0:    head = slot_ff[0];
         2'd1:    head = slot_ff[1];
         2'd2:    head = slot_ff[2];
         default: head = slot_ff[0];
      endcase
   end

   assign rsp_code_unit   = head.code_unit;
   assign rsp_status      = head.status;
   assign rsp_last_of_run = head.last_of_run;

   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         count_in = batch.count;
         index_in = 2'd0;
      end else if (last_take) begin
         count_in = 2'd0;
         index_in = 2'd0;
      end else if (take) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= batch.slot;
      end
   end

endmodule

/* rtl/utf8_to_utf16_transcoder.sv */
// path: req byte to input register, then its results to result register
// throughput: one byte per cycle while rsp_stall is low and each byte gives at
//   most one result; a byte's k results (k up to 3) hold the register until taken
// reset: synchronous active-high; clears the sequence state, discard flag,
//   input register valid and result count; ready in the cycle after reset
module utf8_to_utf16_transcoder
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run
);

   // input register: one byte waiting for decode
   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff;
   logic       req_end_ff;

   logic       req_take;
   logic       load;
   batch_type  batch;

   // the byte moves on whenever the result register is free or drains
   // its last result this cycle, so a new transaction fits behind it
   assign req_stall = req_valid_ff && !load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (load) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff <= req_in_byte;
         req_end_ff  <= req_string_end;
      end
   end

   // decode state advances exactly when the byte is handed to the result register
   u8u16_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_byte_ff),
      .string_end (req_end_ff),
      .step       (load),
      .batch      (batch)
   );

   // bytes with no results (mid-sequence, discarding) leave no rsp pending
   u8u16_result_queue u_result_queue (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (req_valid_ff),
      .batch           (batch),
      .load            (load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* rtl/u8u16_checker.sv */
// port-level checks for the transcoder, attached by bind
// uses u8u16_pkg status codes
module u8u16_checker
   import u8u16_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_in_byte,
   input logic        req_string_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code_unit,
   input logic [1:0]  rsp_status,
   input logic        rsp_last_of_run
);

   // a stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_unit)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   // done and error always close the run of a byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_UNIT) |-> rsp_last_of_run)
      else $error("done or error result not last of run");

   // done and error carry a zero code unit
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_UNIT) |-> (rsp_code_unit == 16'd0))
      else $error("nonzero code unit on status result");

   // reset leaves nothing pending and the input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);
